>>> rtl/ust_pkg.sv
// Package with shared types and constants of the serial transceiver.
`default_nettype none
package ust_pkg;

  localparam int DATA_BITS_DEF   = 8;
  localparam int TIMER_WIDTH_DEF = 16;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int BYTE_W     = 8;

  localparam logic [CFG_IDX_W-1:0]  CFG_BIT_PERIOD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_LOOPBACK_ON = 1'd1;
  localparam logic [CFG_DATA_W-1:0] BIT_PERIOD_RESET = 16'd434;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } rx_result_t;

  typedef struct packed {
    logic line;
    logic busy;
    logic taken;
  } tx_status_t;

endpackage
`default_nettype wire

>>> rtl/ust_rx.sv
// Receiver: start detection, mid-bit sampling and byte assembly.
`default_nettype none
module ust_rx #(
  parameter int DATA_BITS   = ust_pkg::DATA_BITS_DEF,
  parameter int TIMER_WIDTH = ust_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic                   line,
  input  wire logic [TIMER_WIDTH-1:0] reload,
  output ust_pkg::rx_result_t         result
);
  import ust_pkg::*;

  localparam int CNT_W = $clog2(DATA_BITS + 3);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam logic [1:0] PH_STOP  = 2'd3;

  logic [1:0]             phase, phase_next;
  logic [TIMER_WIDTH-1:0] timer, timer_next;
  logic [DATA_BITS-1:0]   shift, shift_next;
  logic [CNT_W-1:0]       cnt, cnt_next;
  logic [CNT_W-1:0]       cnt_inc;

  assign cnt_inc = cnt + CNT_W'(1);

  always_comb begin
    phase_next   = phase;
    timer_next   = timer;
    shift_next   = shift;
    cnt_next     = cnt;
    result.valid = 1'b0;
    result.data  = '0;
    if (phase == PH_IDLE) begin
      if (!line) begin
        phase_next = PH_START;
        timer_next = reload >> 1;
        shift_next = '0;
        cnt_next   = '0;
      end
    end else if (timer > TIMER_WIDTH'(1)) begin
      timer_next = timer - TIMER_WIDTH'(1);
    end else begin
      timer_next = reload;
      priority if (phase == PH_START) begin
        phase_next = PH_DATA;
      end else if (phase == PH_DATA) begin
        shift_next = {line, shift[DATA_BITS-1:1]};
        cnt_next   = cnt_inc;
        if (cnt_inc >= CNT_W'(DATA_BITS)) begin
          phase_next = PH_STOP;
        end
      end else begin
        if (line) begin
          result.valid = 1'b1;
          result.data  = BYTE_W'(shift);
          phase_next   = PH_IDLE;
          cnt_next     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      timer <= '0;
      shift <= '0;
      cnt   <= '0;
    end else if (step) begin
      phase <= phase_next;
      timer <= timer_next;
      shift <= shift_next;
      cnt   <= cnt_next;
    end
  end

  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> cnt == '0)
    else $error("rx bit count not cleared while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DATA_BITS))
    else $error("rx bit count beyond data width");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    step && result.valid |=> phase == PH_IDLE)
    else $error("rx did not return to idle after byte");

endmodule
`default_nettype wire

>>> rtl/ust_tx.sv
// Transmitter: frame shift register and bit timer.
`default_nettype none
module ust_tx #(
  parameter int DATA_BITS   = ust_pkg::DATA_BITS_DEF,
  parameter int TIMER_WIDTH = ust_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic                   req,
  input  wire logic [DATA_BITS-1:0]   data,
  input  wire logic [TIMER_WIDTH-1:0] reload,
  output ust_pkg::tx_status_t         status
);
  import ust_pkg::*;

  localparam int FRAME_BITS = DATA_BITS + 2;
  localparam int LEFT_W     = $clog2(FRAME_BITS + 1);

  logic [FRAME_BITS-1:0]  frame, frame_next;
  logic [LEFT_W-1:0]      left, left_next;
  logic [TIMER_WIDTH-1:0] timer, timer_next;

  always_comb begin
    frame_next   = frame;
    left_next    = left;
    timer_next   = timer;
    status.taken = 1'b0;
    if (left != '0) begin
      if (timer > TIMER_WIDTH'(1)) begin
        timer_next = timer - TIMER_WIDTH'(1);
      end else begin
        frame_next = {1'b1, frame[FRAME_BITS-1:1]};
        left_next  = left - LEFT_W'(1);
        timer_next = reload;
      end
    end
    if (left_next == '0) begin
      frame_next = '1;
      if (req) begin
        frame_next   = {1'b1, data, 1'b0};
        left_next    = LEFT_W'(FRAME_BITS);
        timer_next   = reload;
        status.taken = 1'b1;
      end
    end
    status.busy = (left_next != '0);
    status.line = status.busy ? frame_next[0] : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '1;
      left  <= '0;
      timer <= '0;
    end else if (step) begin
      frame <= frame_next;
      left  <= left_next;
      timer <= timer_next;
    end
  end

  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    left <= LEFT_W'(FRAME_BITS))
    else $error("tx bit count beyond frame length");

  a_idle_frame_ones: assert property (@(posedge clk) disable iff (rst)
    left == '0 |-> frame == '1)
    else $error("tx frame not all ones while idle");

endmodule
`default_nettype wire

>>> rtl/uart_serial_transceiver.sv
// Top level of the 8N1 serial transceiver with input and result registers.
//
// Each input transaction is one tick of the serial line: the sampled level
// line_in plus an optional byte to send (send_valid, send_byte). Each tick
// produces exactly one result transaction: line_out, rx_valid/rx_byte for a
// byte that completed on that tick, tx_busy and send_taken.
// Input transactions move on in_valid/in_stall, results on out_valid/out_stall.
// A tick is captured in the input register at its accepting edge; once it
// advances, the receiver and transmitter state update from it and the result
// lands in the output register, which raises out_valid. One tick is taken
// per cycle while out_stall is low; the rate is set by the single state
// update per cycle. bit_period (index 0) sets ticks per serial bit;
// loopback_on (index 1) copies line_in to line_out. Write them only while
// no tick is in flight. Reset idles both sides, sets bit_period to 434 and
// loopback off; in_stall is low out of reset, so ticks are taken at once.
// While out_valid and out_stall are both high the result holds, the state
// does not advance, and in_stall rises once the input register is full.
`default_nettype none
module uart_serial_transceiver #(
  parameter int DATA_BITS   = ust_pkg::DATA_BITS_DEF,
  parameter int TIMER_WIDTH = ust_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ust_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ust_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           line_in,
  input  wire logic                           send_valid,
  input  wire logic [ust_pkg::BYTE_W-1:0]     send_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                line_out,
  output logic                                rx_valid,
  output logic [ust_pkg::BYTE_W-1:0]          rx_byte,
  output logic                                tx_busy,
  output logic                                send_taken
);
  import ust_pkg::*;

  logic [CFG_DATA_W-1:0] bit_period;
  logic                  loopback_on;

  logic              s1_valid;
  logic              s1_line;
  logic              s1_req;
  logic [BYTE_W-1:0] s1_data;
  logic              s1_adv;
  logic              in_accept;

  logic [TIMER_WIDTH-1:0] reload;
  rx_result_t             rx_res;
  tx_status_t             tx_st;

  assign reload    = TIMER_WIDTH'(bit_period);
  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period  <= BIT_PERIOD_RESET;
      loopback_on <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BIT_PERIOD:  bit_period  <= cfg_data;
        CFG_LOOPBACK_ON: loopback_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_line <= line_in;
      s1_req  <= send_valid;
      s1_data <= send_byte;
    end
  end

  ust_rx #(
    .DATA_BITS  (DATA_BITS),
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_rx (
    .clk   (clk),
    .rst   (rst),
    .step  (s1_adv),
    .line  (s1_line),
    .reload(reload),
    .result(rx_res)
  );

  ust_tx #(
    .DATA_BITS  (DATA_BITS),
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_tx (
    .clk   (clk),
    .rst   (rst),
    .step  (s1_adv),
    .req   (s1_req),
    .data  (DATA_BITS'(s1_data)),
    .reload(reload),
    .status(tx_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_out   <= loopback_on ? s1_line : tx_st.line;
      rx_valid   <= rx_res.valid;
      rx_byte    <= rx_res.data;
      tx_busy    <= tx_st.busy;
      send_taken <= tx_st.taken;
    end
  end

  a_taken_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_taken |-> tx_busy)
    else $error("send taken without busy transmitter");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_data) && $stable(s1_line))
    else $error("input register lost a held transaction");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("result register not loaded after advance");

endmodule
`default_nettype wire

>>> test/tb.sv
// Self-checking testbench of the 8N1 serial transceiver with a per-tick line predictor.
module tb;
  import ust_pkg::*;

  typedef enum logic [1:0] {RX_IDLE, RX_START, RX_DATA, RX_STOP} rcv_state_e;
  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  typedef struct packed {
    rx_result_t rx;
    tx_status_t tx;
  } tick_result_t;

  typedef struct packed {
    row_kind_e           kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                ln;
    logic                rq;
    logic [BYTE_W-1:0]   b;
    logic                typed;
    tick_result_t        want;
  } plan_row_t;

  localparam int FRAME_LEN = DATA_BITS_DEF + 2;
  localparam int HOLD_CYCLES = 200;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  line_in = 1'b1;
  logic                  send_valid = 1'b0;
  logic [BYTE_W-1:0]     send_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  line_out;
  logic                  rx_valid;
  logic [BYTE_W-1:0]     rx_byte;
  logic                  tx_busy;
  logic                  send_taken;

  logic                  hold_trigger = 1'b0;
  int                    hold_left = 0;
  int                    send_idle_pct = 24;
  int                    recv_idle_pct = 71;
  int                    mismatches = 0;
  tick_result_t          pending_results[$];

  logic [CFG_DATA_W-1:0] period_reg;
  logic                  loop_reg;
  rcv_state_e            rcv_state;
  logic [15:0]           rcv_timer;
  logic [7:0]            rcv_shreg;
  logic [3:0]            rcv_bits;
  logic [FRAME_LEN-1:0]  xmt_frame;
  logic [3:0]            xmt_bits;
  logic [15:0]           xmt_timer;

  uart_serial_transceiver dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .line_in(line_in), .send_valid(send_valid), .send_byte(send_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .line_out(line_out), .rx_valid(rx_valid), .rx_byte(rx_byte),
    .tx_busy(tx_busy), .send_taken(send_taken)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic tick_result_t advance_tick(input logic ln, input logic rq,
                                                input logic [BYTE_W-1:0] b);
    tick_result_t r;
    r = '0;
    if (rcv_state == RX_IDLE) begin
      if (!ln) begin
        rcv_state = RX_START;
        rcv_timer = period_reg >> 1;
        rcv_shreg = '0;
        rcv_bits  = '0;
      end
    end else if (rcv_timer > 16'd1) begin
      rcv_timer = rcv_timer - 16'd1;
    end else begin
      rcv_timer = period_reg;
      if (rcv_state == RX_START) begin
        rcv_state = RX_DATA;
      end else if (rcv_state == RX_DATA) begin
        rcv_shreg = {ln, rcv_shreg[7:1]};
        rcv_bits  = rcv_bits + 4'd1;
        if (rcv_bits >= DATA_BITS_DEF) rcv_state = RX_STOP;
      end else if (ln) begin
        r.rx.valid = 1'b1;
        r.rx.data  = rcv_shreg;
        rcv_state  = RX_IDLE;
        rcv_bits   = '0;
      end
    end

    if (xmt_bits != 4'd0) begin
      if (xmt_timer > 16'd1) begin
        xmt_timer = xmt_timer - 16'd1;
      end else begin
        xmt_frame = {1'b1, xmt_frame[FRAME_LEN-1:1]};
        xmt_bits  = xmt_bits - 4'd1;
        xmt_timer = period_reg;
      end
    end
    if (xmt_bits == 4'd0) begin
      xmt_frame = '1;
      if (rq) begin
        xmt_frame  = {1'b1, b, 1'b0};
        xmt_bits   = 4'(FRAME_LEN);
        xmt_timer  = period_reg;
        r.tx.taken = 1'b1;
      end
    end
    r.tx.busy = (xmt_bits != 4'd0);
    r.tx.line = loop_reg ? ln : (r.tx.busy ? xmt_frame[0] : 1'b1);
    return r;
  endfunction

  function automatic plan_row_t tick_row(input logic ln, input logic rq,
                                         input logic [BYTE_W-1:0] b);
    plan_row_t row;
    row = '0;
    row.kind = ROW_TICK;
    row.ln = ln;
    row.rq = rq;
    row.b = b;
    return row;
  endfunction

  function automatic plan_row_t checked_row(input logic ln, input logic rq,
                                            input logic [BYTE_W-1:0] b,
                                            input logic lo, input logic v,
                                            input logic [BYTE_W-1:0] d,
                                            input logic busy, input logic taken);
    plan_row_t row;
    row = tick_row(ln, rq, b);
    row.typed = 1'b1;
    row.want.tx.line = lo;
    row.want.rx.valid = v;
    row.want.rx.data = d;
    row.want.tx.busy = busy;
    row.want.tx.taken = taken;
    return row;
  endfunction

  function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  task automatic push_tick(input logic ln, input logic rq, input logic [BYTE_W-1:0] b,
                           input logic typed, input tick_result_t want);
    tick_result_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    line_in    <= ln;
    send_valid <= rq;
    send_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = advance_tick(ln, rq, b);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BIT_PERIOD:  period_reg = val;
      CFG_LOOPBACK_ON: loop_reg = val[0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_trigger) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    tick_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (line_out !== want.tx.line) begin
          $error("line_out: expected %0b, got %0b", want.tx.line, line_out);
          mismatches++;
        end
        if (rx_valid !== want.rx.valid) begin
          $error("rx_valid: expected %0b, got %0b", want.rx.valid, rx_valid);
          mismatches++;
        end
        if (rx_byte !== want.rx.data) begin
          $error("rx_byte: expected %02h, got %02h", want.rx.data, rx_byte);
          mismatches++;
        end
        if (tx_busy !== want.tx.busy) begin
          $error("tx_busy: expected %0b, got %0b", want.tx.busy, tx_busy);
          mismatches++;
        end
        if (send_taken !== want.tx.taken) begin
          $error("send_taken: expected %0b, got %0b", want.tx.taken, send_taken);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t             plan[$];
    logic                  line_script[$];
    logic [CFG_DATA_W-1:0] per;
    logic                  lb;
    int                    cnt;
    int                    n;
    logic [BYTE_W-1:0]     fb;
    logic                  ln;
    logic                  rq;

    period_reg = BIT_PERIOD_RESET;
    loop_reg   = 1'b0;
    rcv_state  = RX_IDLE;
    rcv_timer  = '0;
    rcv_shreg  = '0;
    rcv_bits   = '0;
    xmt_frame  = '1;
    xmt_bits   = '0;
    xmt_timer  = '0;

    plan.push_back(checked_row(1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    plan.push_back(write_row(CFG_BIT_PERIOD, 16'd0));
    plan.push_back(checked_row(1'b1, 1'b1, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1));
    plan.push_back(tick_row(1'b1, 1'b1, 8'h00));
    plan.push_back(tick_row(1'b0, 1'b0, 8'h00));
    plan.push_back(tick_row(1'b1, 1'b0, 8'h00));
    plan.push_back(tick_row(1'b1, 1'b0, 8'h00));
    plan.push_back(tick_row(1'b0, 1'b0, 8'h00));
    plan.push_back(tick_row(1'b1, 1'b0, 8'h00));
    plan.push_back(tick_row(1'b0, 1'b0, 8'h00));
    plan.push_back(tick_row(1'b0, 1'b0, 8'h00));
    plan.push_back(tick_row(1'b1, 1'b0, 8'h00));
    plan.push_back(checked_row(1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1));
    plan.push_back(tick_row(1'b1, 1'b0, 8'h00));
    plan.push_back(tick_row(1'b0, 1'b0, 8'h00));
    plan.push_back(tick_row(1'b1, 1'b0, 8'h00));
    plan.push_back(write_row(CFG_LOOPBACK_ON, 16'd1));
    plan.push_back(tick_row(1'b0, 1'b0, 8'h00));
    plan.push_back(tick_row(1'b1, 1'b0, 8'h00));
    plan.push_back(tick_row(1'b1, 1'b1, 8'h5A));
    plan.push_back(write_row(CFG_LOOPBACK_ON, 16'd0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        push_tick(plan[i].ln, plan[i].rq, plan[i].b, plan[i].typed, plan[i].want);
      end
    end

    n = 0;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin per = 16'd2; lb = 1'b0; cnt = 150; end
        1: begin per = 16'd3; lb = 1'b1; cnt = 100; end
        2: begin per = 16'd1; lb = 1'b0; cnt = 80; end
        3: begin per = 16'd5; lb = 1'b0; cnt = 130; end
        4: begin per = 16'hFFFF; lb = 1'b0; cnt = 10; end
        5: begin per = 16'd2; lb = 1'b1; cnt = 80; end
        6: begin per = 16'd7; lb = 1'b0; cnt = 120; end
        default: begin per = 16'd4; lb = 1'b0; cnt = 100; end
      endcase
      if (per == 16'hFFFF) begin
        while (rcv_state != RX_IDLE || xmt_bits != 4'd0) push_tick(1'b1, 1'b0, 8'h00, 1'b0, '0);
      end
      write_reg(CFG_BIT_PERIOD, per);
      write_reg(CFG_LOOPBACK_ON, {15'd0, lb});
      line_script.delete();
      if (p == 3) begin
        hold_trigger <= 1'b1;
        @(posedge clk);
        hold_trigger <= 1'b0;
      end
      repeat (cnt) begin
        if (n == 260) begin
          send_idle_pct = 71;
          recv_idle_pct <= 24;
        end else if (n == 520) begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
        if (per == 16'hFFFF) begin
          ln = 1'b1;
          rq = 1'b0;
        end else begin
          if (line_script.size() == 0) begin
            if ($urandom_range(99) < 80) begin
              fb = 8'($urandom_range(255));
              repeat (per) line_script.push_back(1'b0);
              for (int k = 0; k < DATA_BITS_DEF; k++) repeat (per) line_script.push_back(fb[k]);
              if ($urandom_range(9) == 0) repeat (per) line_script.push_back(1'b0);
              repeat (per + $urandom_range(2 * per)) line_script.push_back(1'b1);
            end else begin
              repeat ($urandom_range(8, 1)) line_script.push_back(1'($urandom_range(1)));
            end
          end
          ln = line_script.pop_front();
          rq = ($urandom_range(99) < 30);
        end
        push_tick(ln, rq, 8'($urandom_range(255)), 1'b0, '0);
        n++;
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
